// ===== rtl/rnrb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnrb_pkg: shared types and constants of the RTC nibble register bank
// Word formats, operation codes, bank geometry and the divide-by-ten helper.
// ----------------------------------------------------------------------------
package rnrb_pkg;

    localparam logic [1:0] OpSelect = 2'd0;
    localparam logic [1:0] OpWrite  = 2'd1;
    localparam logic [1:0] OpRead   = 2'd2;

    localparam logic [3:0] NibbleMask = 4'hF;
    localparam logic [7:0] ReadHigh   = 8'hF0;
    localparam logic [3:0] ModeReg    = 4'd13;
    localparam int         BankRegs   = 13;
    localparam int         BankCount  = 4;
    localparam int         StoreDepth = BankRegs * BankCount;
    localparam int         StoreAw    = $clog2(StoreDepth);

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_in;
        logic [5:0] time_seconds;
        logic [5:0] time_minutes;
        logic [4:0] time_hours;
        logic [2:0] time_weekday;
        logic [4:0] time_day;
        logic [3:0] time_month;
        logic [7:0] time_years_since_1980;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
    } t_out_word;

    typedef struct packed {
        logic               wr_en;
        logic [StoreAw-1:0] wr_addr;
        logic [3:0]         wr_data;
        logic               rd_en;
        logic [StoreAw-1:0] rd_addr;
    } t_store_req;

    typedef struct packed {
        logic [7:0] quo;
        logic [3:0] rem;
    } t_divmod;

    // Quotient by 205/2048, exact for every 8-bit value.
    function automatic t_divmod divmod10(input logic [7:0] x);
        logic [18:0] prod;
        logic [7:0]  q;
        logic [11:0] q10;
        t_divmod     res;
        prod     = {11'd0, x} * 19'd205;
        q        = prod[18:11];
        q10      = {4'd0, q} * 12'd10;
        res.quo  = q;
        res.rem  = 4'(x - q10[7:0]);
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rnrb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnrb_if: valid/ready channels of the RTC nibble register bank
// One channel carries access words in, the other carries read words out.
// ----------------------------------------------------------------------------
interface rnrb_in_if;
    import rnrb_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rnrb_out_if;
    import rnrb_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/rtc_nibble_register_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_nibble_register_bank: RTC nibble register bank
// Select, write and read accesses on a bank of CMOS nibbles and clock digits.
// ----------------------------------------------------------------------------
// One access word is taken every cycle while the result is not stalled. A
// word is registered on entry, and is decoded and applied to the register
// state once the result stage can advance. A read returns its byte from the
// result register, or for a stored nibble from the registered read port of
// the nibble store. Select and write words give no result. The store is
// usable at once after reset.
module rtc_nibble_register_bank (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rnrb_in_if.sink    i_in,
    rnrb_out_if.source o_out
);
    import rnrb_pkg::*;

    logic       r_a_valid;
    t_in_word   r_a_word;
    logic       r_b_valid;
    logic       r_b_from_mem;
    logic [3:0] r_b_nib;
    logic [3:0] r_sel;
    logic [3:0] r_mode;

    logic [3:0]         n_sel;
    logic [3:0]         n_mode;
    logic               n_b_from_mem;
    logic [3:0]         n_b_nib;
    logic               advance;
    logic               a_fire;
    logic [3:0]         in_nib;
    logic               in_bank;
    logic [1:0]         bank;
    logic [StoreAw-1:0] addr;
    logic [3:0]         digit;
    logic [3:0]         rd_data;
    t_store_req         req;

    assign advance    = !r_b_valid || o_out.ready;
    assign a_fire     = r_a_valid && advance;
    assign i_in.ready = !r_a_valid || advance;

    assign in_nib  = r_a_word.data_in[3:0];
    assign bank    = r_mode[1:0];
    assign in_bank = r_sel < ModeReg;
    assign addr    = StoreAw'({4'd0, bank} * 6'(BankRegs)) + StoreAw'(r_sel);

    rnrb_digit u_digit (
        .i_reg   (r_sel),
        .i_word  (r_a_word),
        .o_digit (digit)
    );

    always_comb begin
        n_sel        = r_sel;
        n_mode       = r_mode;
        n_b_from_mem = 1'b0;
        n_b_nib      = NibbleMask;
        req.wr_en    = 1'b0;
        req.wr_addr  = addr;
        req.wr_data  = in_nib;
        req.rd_en    = 1'b0;
        req.rd_addr  = addr;
        if (a_fire) begin
            unique case (r_a_word.operation)
                OpSelect: n_sel = in_nib;
                OpWrite: begin
                    if (in_bank) begin
                        req.wr_en = 1'b1;
                    end else if (r_sel == ModeReg) begin
                        n_mode = in_nib;
                    end
                end
                OpRead: begin
                    priority if (r_sel == ModeReg) begin
                        n_b_nib = r_mode;
                    end else if (!in_bank) begin
                        n_b_nib = NibbleMask;
                    end else if (bank == 2'd0) begin
                        n_b_nib = digit;
                    end else begin
                        n_b_from_mem = 1'b1;
                        req.rd_en    = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    rnrb_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_sel     <= 4'd0;
            r_mode    <= 4'd0;
        end else begin
            r_sel  <= n_sel;
            r_mode <= n_mode;
            if (i_in.ready) begin
                r_a_valid <= i_in.valid;
            end
            if (advance) begin
                r_b_valid <= a_fire && (r_a_word.operation == OpRead);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_a_word <= i_in.payload;
        end
        if (a_fire) begin
            r_b_from_mem <= n_b_from_mem;
            r_b_nib      <= n_b_nib;
        end
    end

    assign o_out.valid             = r_b_valid;
    assign o_out.payload.read_data = ReadHigh | {4'd0, (r_b_from_mem ? rd_data : r_b_nib)};

endmodule
`default_nettype wire

// ===== rtl/rnrb_digit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnrb_digit: clock digit decode
// Turns the binary time fields into the decimal nibble of one bank 0 register.
// ----------------------------------------------------------------------------
module rnrb_digit (
    input  wire  logic [3:0]         i_reg,
    input  wire  rnrb_pkg::t_in_word i_word,
    output logic [3:0]               o_digit
);
    import rnrb_pkg::*;

    logic [7:0] operand;
    t_divmod    dm;
    t_divmod    dm_hi;

    always_comb begin
        unique case (i_reg)
            4'd0, 4'd1:   operand = {2'd0, i_word.time_seconds};
            4'd2, 4'd3:   operand = {2'd0, i_word.time_minutes};
            4'd4, 4'd5:   operand = {3'd0, i_word.time_hours};
            4'd7, 4'd8:   operand = {3'd0, i_word.time_day};
            4'd9, 4'd10:  operand = {4'd0, i_word.time_month};
            default:      operand = i_word.time_years_since_1980;
        endcase
    end

    assign dm    = divmod10(operand);
    // The years tens digit wraps at ten, so the quotient is split once more.
    assign dm_hi = divmod10(dm.quo);

    always_comb begin
        unique case (i_reg)
            4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd11: o_digit = dm.rem;
            4'd1, 4'd3, 4'd5, 4'd8, 4'd10:       o_digit = dm.quo[3:0];
            4'd6:                                o_digit = {1'b0, i_word.time_weekday};
            4'd12:                               o_digit = dm_hi.rem;
            default:                             o_digit = NibbleMask;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/rnrb_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnrb_store: CMOS nibble store
// Four banks of thirteen nibbles in one memory with a registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module rnrb_store (
    input  wire  logic                 i_clk,
    input  wire  logic                 i_rst_n,
    input  wire  rnrb_pkg::t_store_req i_req,
    output logic [3:0]                 o_rd_data
);
    import rnrb_pkg::*;

    logic [3:0]            r_mem [StoreDepth];
    logic [StoreDepth-1:0] r_written;
    logic [3:0]            r_rd_data;
    logic                  r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_written <= r_written[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_data : 4'd0;

endmodule
`default_nettype wire

// ===== rtl/rnrb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnrb_checker: port-level checks of the RTC nibble register bank
// Watches both channels of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module rnrb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic [1:0] i_in_op,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_data
);
    import rnrb_pkg::*;

    // A stalled read word holds its byte.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("read word changed while stalled");

    a_high_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data[7:4] == 4'hF)
        else $error("read word upper nibble not all ones");

    // A fresh result always comes from an accepted read word, registered on entry and then in the result register.
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_op == OpRead, 2))
        else $error("result without a matching read");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with no pending result");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

endmodule

bind rtc_nibble_register_bank rnrb_checker u_rnrb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.payload.operation),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.payload.read_data)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the RTC nibble register bank
// Directed and random select, write, read and unused-code accesses are sent over the input
// channel. A scoreboard tracks the register number, mode and CMOS banks,
// works out every read byte, and compares it with the bytes from the block.
// ----------------------------------------------------------------------------
module tb_top;
    import rnrb_pkg::*;

    localparam logic [1:0] OpUnused   = 2'd3;
    localparam logic [3:0] SpareRegLo = 4'd14;
    localparam logic [3:0] SpareRegHi = 4'd15;
    localparam int         RandomAccesses = 750;
    localparam int         StallLimit     = 2000;
    localparam int         SettleCycles   = 8;
    localparam int         ReportLimit    = 10;

    class rtc_bank_scoreboard;
        logic [3:0] sel_q;
        logic [3:0] mode_q;
        logic [3:0] bank_nibbles[BankCount*BankRegs];
        logic [7:0] expected_reads[$];
        int         errors;
        int         accesses;
        int         reads_checked;
        int         clock_reads;
        int         mode_changes;

        function new();
            sel_q  = '0;
            mode_q = '0;
            foreach (bank_nibbles[i]) bank_nibbles[i] = '0;
        endfunction

        function void report(string what, logic [7:0] want, logic [7:0] got);
            errors++;
            if (errors <= ReportLimit)
                $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
        endfunction

        // Updates the register state for an accepted word and queues the byte
        // that a read must return.
        function void note_access(t_in_word w);
            logic [3:0]  nib;
            logic [3:0]  value;
            int unsigned bank;
            int unsigned sec, mins, hr, day, mon, yr;
            nib  = w.data_in[3:0];
            bank = int'(mode_q[1:0]);
            sec  = w.time_seconds;
            mins = w.time_minutes;
            hr   = w.time_hours;
            day  = w.time_day;
            mon  = w.time_month;
            yr   = w.time_years_since_1980;
            accesses++;
            case (w.operation)
                OpSelect: sel_q = nib;
                OpWrite: begin
                    if (sel_q < ModeReg) begin
                        bank_nibbles[bank*BankRegs + int'(sel_q)] = nib;
                    end else if (sel_q == ModeReg) begin
                        mode_q = nib;
                        mode_changes++;
                    end
                end
                OpRead: begin
                    if (sel_q == ModeReg) begin
                        value = mode_q;
                    end else if (sel_q > ModeReg) begin
                        value = NibbleMask;
                    end else if (bank == 0) begin
                        // Bank 0 shows the time digits, never the stored nibbles.
                        clock_reads++;
                        case (sel_q)
                            4'd0:    value = 4'(sec % 10);
                            4'd1:    value = 4'(sec / 10);
                            4'd2:    value = 4'(mins % 10);
                            4'd3:    value = 4'(mins / 10);
                            4'd4:    value = 4'(hr % 10);
                            4'd5:    value = 4'(hr / 10);
                            4'd6:    value = 4'(w.time_weekday);
                            4'd7:    value = 4'(day % 10);
                            4'd8:    value = 4'(day / 10);
                            4'd9:    value = 4'(mon % 10);
                            4'd10:   value = 4'(mon / 10);
                            4'd11:   value = 4'(yr % 10);
                            default: value = 4'((yr / 10) % 10);
                        endcase
                    end else begin
                        value = bank_nibbles[bank*BankRegs + int'(sel_q)];
                    end
                    expected_reads.push_back(ReadHigh | {4'd0, value});
                end
                default: ;
            endcase
        endfunction

        function void check_read(t_out_word r);
            logic [7:0] want;
            if (expected_reads.size() == 0) begin
                report("read word with none expected", 8'hxx, r.read_data);
            end else begin
                want = expected_reads.pop_front();
                reads_checked++;
                if (r.read_data !== want) report("read_data mismatch", want, r.read_data);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   idle_cycles = 0;
    int   sent;
    bit   timed_out;

    rnrb_in_if  in_ch ();
    rnrb_out_if out_ch ();

    rtc_bank_scoreboard sb = new();

    rtc_nibble_register_bank u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Results are checked before the inputs of the same edge are noted; a
    // read word can never come out in the cycle that it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) sb.check_read(out_ch.payload);
            if (in_ch.valid && in_ch.ready) sb.note_access(in_ch.payload);
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Time fields are mostly in range, now and then raw values of full width.
    function automatic t_in_word make_access(logic [1:0] op, logic [7:0] data);
        t_in_word w;
        w.operation = op;
        w.data_in   = data;
        if ($urandom_range(99) < 15) begin
            w.time_seconds          = 6'($urandom);
            w.time_minutes          = 6'($urandom);
            w.time_hours            = 5'($urandom);
            w.time_weekday          = 3'($urandom);
            w.time_day              = 5'($urandom);
            w.time_month            = 4'($urandom);
        end else begin
            w.time_seconds          = 6'($urandom_range(59));
            w.time_minutes          = 6'($urandom_range(59));
            w.time_hours            = 5'($urandom_range(23));
            w.time_weekday          = 3'($urandom_range(6));
            w.time_day              = 5'($urandom_range(31, 1));
            w.time_month            = 4'($urandom_range(12, 1));
        end
        w.time_years_since_1980 = 8'($urandom);
        return w;
    endfunction

    task automatic send_access(t_in_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid   <= 1'b0;
            in_ch.payload <= t_in_word'({$urandom, $urandom});
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic send_simple(logic [1:0] op, logic [7:0] data);
        send_access(make_access(op, data));
    endtask

    task automatic run_directed();
        t_in_word w;
        w = make_access(OpRead, 8'h00);
        w.time_seconds = '0;
        w.time_minutes = '0;
        w.time_hours   = '0;
        w.time_weekday = '0;
        w.time_day     = '0;
        w.time_month   = '0;
        w.time_years_since_1980 = '0;
        send_access(w);
        send_simple(OpSelect, {4'hF, ModeReg});
        send_simple(OpRead, 8'h00);
        send_simple(OpUnused, 8'hFF);
        send_simple(OpWrite, 8'hF2);
        send_simple(OpRead, 8'hFF);
        send_simple(OpSelect, 8'hE5);
        send_simple(OpWrite, 8'hA7);
        send_simple(OpRead, 8'h00);
        send_simple(OpSelect, {4'h0, SpareRegLo});
        send_simple(OpWrite, 8'h3C);
        send_simple(OpRead, 8'h00);
        send_simple(OpSelect, {4'h0, SpareRegHi});
        send_simple(OpRead, 8'h00);
        // Back to bank 0: the reads now show clock digits at their extremes.
        send_simple(OpSelect, {4'h0, ModeReg});
        send_simple(OpWrite, 8'h00);
        send_simple(OpSelect, 8'h0C);
        w = make_access(OpRead, 8'h00);
        w.time_years_since_1980 = 8'hFF;
        send_access(w);
        send_simple(OpSelect, 8'h01);
        w = make_access(OpRead, 8'h00);
        w.time_seconds = 6'h3F;
        send_access(w);
        send_simple(OpSelect, 8'h04);
        send_simple(OpWrite, 8'h09);
        w = make_access(OpRead, 8'h00);
        w.time_hours = 5'h1F;
        send_access(w);
        send_simple(OpSelect, 8'h06);
        w = make_access(OpRead, 8'h00);
        w.time_weekday = 3'h7;
        send_access(w);
    endtask

    // Mostly a select followed by a few writes and reads; the rest is single
    // words of any operation code.
    task automatic run_random(int count);
        int         stop_at;
        int         burst;
        logic [3:0] target;
        stop_at = sent + count;
        while (sent < stop_at) begin
            if ($urandom_range(99) < 80) begin
                target = ($urandom_range(9) == 0) ? ModeReg : 4'($urandom_range(15));
                send_simple(OpSelect, {4'($urandom), target});
                burst = $urandom_range(4, 1);
                repeat (burst) begin
                    if ($urandom_range(99) < 40) send_simple(OpWrite, 8'($urandom));
                    else send_simple(OpRead, 8'($urandom));
                end
            end else begin
                send_simple(2'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        i_rst_n       <= 1'b0;
        tx_idle_pct = 6;
        rx_idle_pct = 54;
        sent        = 0;
        timed_out   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            begin
                run_directed();
                run_random(RandomAccesses / 3);
                tx_idle_pct = 54;
                rx_idle_pct = 6;
                run_random(RandomAccesses / 3);
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                run_random(RandomAccesses / 3);
                in_ch.valid <= 1'b0;
                while (sb.expected_reads.size() != 0) @(posedge i_clk);
                repeat (SettleCycles) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= StallLimit);
                timed_out = 1'b1;
            end
        join_any
        $display("Sent %0d accesses with %0d mode writes; checked %0d read words,",
                 sb.accesses, sb.mode_changes, sb.reads_checked);
        $display("%0d of them clock digits, across three handshake pacing phases.",
                 sb.clock_reads);
        if (!timed_out && sb.errors == 0 && sb.expected_reads.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rnrb_pkg.sv
rtl/rnrb_if.sv
rtl/rnrb_digit.sv
rtl/rnrb_store.sv
rtl/rtc_nibble_register_bank.sv
rtl/rnrb_checker.sv
dv/tb_top.sv
